// ===== rtl/handheld_console_timer_defines.svh =====
// Assertion macros for the handheld console timer.
// Included by hct_core, the RTL file that carries concurrent assertions; depends on nothing else.
`ifndef HANDHELD_CONSOLE_TIMER_DEFINES_SVH
`define HANDHELD_CONSOLE_TIMER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property with the active-low reset as a disable condition.
`define HCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("handheld_console_timer: assertion failed");

// Checked property that also holds during reset.
`define HCT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("handheld_console_timer: assertion failed");

`else

`define HCT_ASSERT(label, clk, rst_n, prop)
`define HCT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/hct_pkg.sv =====
// Shared types and constants for the handheld console timer.
// Used by hct_core and handheld_console_timer; depends on nothing else.
`timescale 1ns / 1ps

package hct_pkg;

    // Bus command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register select codes.
    localparam logic [1:0] SEL_DIV  = 2'd0;
    localparam logic [1:0] SEL_TIMA = 2'd1;
    localparam logic [1:0] SEL_TMA  = 2'd2;
    localparam logic [1:0] SEL_TAC  = 2'd3;

    // Divider value after reset.
    localparam logic [15:0] DIV_START_RESET = 16'hABC8;

    // Bits that read back as ones above the control field.
    localparam logic [7:0] TAC_READ_FILL = 8'hF8;

    // Reload sequence after a counter overflow.
    typedef enum logic [2:0] {
        PH_NONE = 3'b001,
        PH_OVF  = 3'b010,
        PH_IRQ  = 3'b100
    } hct_phase_t;

    // One input item.
    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
    } hct_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } hct_result_t;

    // Divider bit watched for each rate code.
    function automatic logic [3:0] rate_bit(input logic [1:0] rate);
        logic [3:0] bit_idx;
        unique case (rate)
            2'd0:    bit_idx = 4'd9;
            2'd1:    bit_idx = 4'd3;
            2'd2:    bit_idx = 4'd5;
            default: bit_idx = 4'd7;
        endcase
        return bit_idx;
    endfunction

endpackage

// ===== rtl/hct_core.sv =====
// Timer state registers and the combinational update for one item.
// Depends on hct_pkg and handheld_console_timer_defines.svh.
`timescale 1ns / 1ps
`include "handheld_console_timer_defines.svh"

module hct_core
    import hct_pkg::*;
#(
    parameter int CLOCKS_PER_TICK = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          exec,
    input  hct_item_t     item,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    output hct_result_t   result
);

    logic [15:0] div_reg,   div_next;
    logic [7:0]  tima_reg,  tima_next;
    logic [7:0]  tma_reg,   tma_next;
    logic [2:0]  tac_reg,   tac_next;
    logic        prev_reg,  prev_next;
    hct_phase_t  phase_reg, phase_next;

    logic [15:0] div_step;
    logic        tap_bit;
    logic [7:0]  rd_byte;
    logic        irq;

    // Next state for the item being executed.
    always_comb begin
        div_next   = div_reg;
        tima_next  = tima_reg;
        tma_next   = tma_reg;
        tac_next   = tac_reg;
        prev_next  = prev_reg;
        phase_next = phase_reg;
        rd_byte    = '0;
        irq        = 1'b0;
        div_step   = div_reg;
        tap_bit    = 1'b0;
        if (exec) begin
            unique case (item.cmd)
                CMD_TICK: begin
                    // A pending overflow reloads from modulo and raises the interrupt.
                    unique case (phase_reg)
                        PH_OVF: begin
                            tima_next  = tma_reg;
                            irq        = 1'b1;
                            phase_next = PH_IRQ;
                        end
                        default: begin
                            phase_next = PH_NONE;
                        end
                    endcase
                    // The clock steps of one machine cycle, unrolled.
                    for (int i = 0; i < CLOCKS_PER_TICK; i++) begin
                        div_step = div_reg + 16'(i + 1);
                        tap_bit  = tac_reg[2] && div_step[rate_bit(tac_reg[1:0])];
                        if (prev_next && !tap_bit) begin
                            if (tima_next == 8'hFF) begin
                                tima_next  = '0;
                                phase_next = PH_OVF;
                            end else begin
                                tima_next = tima_next + 8'd1;
                            end
                        end
                        prev_next = tap_bit;
                    end
                    div_next = div_reg + 16'(CLOCKS_PER_TICK);
                end
                CMD_WRITE: begin
                    unique case (item.reg_sel)
                        SEL_DIV: begin
                            div_next = '0;
                        end
                        SEL_TIMA: begin
                            // An overflow not yet reloaded is cancelled; the reload
                            // window itself ignores the write.
                            if (phase_reg == PH_OVF) begin
                                tima_next  = item.write_data;
                                phase_next = PH_NONE;
                            end else if (phase_reg != PH_IRQ) begin
                                tima_next = item.write_data;
                            end
                        end
                        SEL_TMA: begin
                            tma_next = item.write_data;
                            if (phase_reg == PH_IRQ) begin
                                tima_next = item.write_data;
                            end
                        end
                        default: begin
                            // Disabling while the watched bit is high counts one edge.
                            tac_next = item.write_data[2:0];
                            if (prev_reg && !item.write_data[2]) begin
                                if (tima_reg == 8'hFF) begin
                                    tima_next  = '0;
                                    phase_next = PH_OVF;
                                end else begin
                                    tima_next = tima_reg + 8'd1;
                                end
                                prev_next = 1'b0;
                            end
                        end
                    endcase
                end
                CMD_READ: begin
                    unique case (item.reg_sel)
                        SEL_DIV:  rd_byte = div_reg[15:8];
                        SEL_TIMA: rd_byte = tima_reg;
                        SEL_TMA:  rd_byte = tma_reg;
                        default:  rd_byte = TAC_READ_FILL | {5'd0, tac_reg};
                    endcase
                end
                default: begin
                    rd_byte = '0;
                end
            endcase
        end
    end

    assign result.read_data = rd_byte;
    assign result.timer_irq = irq;

    // Timer state; a configuration write reloads the divider and holds all other state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg   <= DIV_START_RESET;
            tima_reg  <= '0;
            tma_reg   <= '0;
            tac_reg   <= '0;
            prev_reg  <= 1'b0;
            phase_reg <= PH_NONE;
        end else if (cfg_we) begin
            div_reg <= cfg_data;
        end else begin
            div_reg   <= div_next;
            tima_reg  <= tima_next;
            tma_reg   <= tma_next;
            tac_reg   <= tac_next;
            prev_reg  <= prev_next;
            phase_reg <= phase_next;
        end
    end

    // The interrupt comes only from a tick that finds an overflow pending.
    `HCT_ASSERT(a_irq_source, aclk, aresetn, irq |-> (exec && item.cmd == CMD_TICK && phase_reg == PH_OVF))

    // After raising the interrupt the counter sits in the reload window, or has
    // overflowed again when the reloaded value wrapped within the same tick.
    `HCT_ASSERT(a_irq_window, aclk, aresetn, (irq && !cfg_we) |=> (phase_reg != PH_NONE))

    // Reads are the only items that return a nonzero byte.
    `HCT_ASSERT(a_rd_only_read, aclk, aresetn, (rd_byte != 8'd0) |-> (exec && item.cmd == CMD_READ))

    // A divider write clears the whole divider.
    `HCT_ASSERT(a_div_clear, aclk, aresetn, (exec && !cfg_we && item.cmd == CMD_WRITE && item.reg_sel == SEL_DIV) |=> (div_reg == 16'd0))

endmodule

// ===== rtl/handheld_console_timer.sv =====
// Top level of the handheld console timer: stream ports, input and result registers.
// Depends on hct_pkg and hct_core.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_tvalid / s_tready    s_tdata: write_data; s_tuser: cmd, reg_sel
//  m_        out        m_tvalid / m_tready    m_tdata: read_data;  m_tuser: timer_irq
//  cfg_      in         cfg_valid / cfg_ready  cfg_data: divider start value
//
//  Each item passes through the input register, the combinational timer update and
//  the result register, and one item is accepted in every cycle while m_tready is high.
//  The rate is set by the combinational state update in hct_core, which unrolls all
//  clock steps of a machine cycle into one pass.
//  Reset is synchronous on aresetn; the divider starts at 0xABC8 and cfg writes reload it.
//  With m_tready low and a result held, the input register takes one more item if empty.

module handheld_console_timer
    import hct_pkg::*;
#(
    parameter int CLOCKS_PER_TICK = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] write_data
    input  logic [3:0]  s_tuser,    // [1:0] cmd, [3:2] reg_sel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] read_data
    output logic [0:0]  m_tuser,    // [0] timer_irq
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    hct_item_t   item_reg;
    logic        item_valid_reg;
    logic [7:0]  rd_reg;
    logic        irq_reg;
    logic        m_valid_reg;
    logic        advance;
    logic        exec;
    hct_result_t result;

    // Handshake: the result register frees up when empty or taken.
    assign advance   = !m_valid_reg || m_tready;
    assign exec      = item_valid_reg && advance;
    assign s_tready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Valid flags of the two register stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                item_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= item_valid_reg;
            end
        end
    end

    // Input item register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd        <= s_tuser[1:0];
            item_reg.reg_sel    <= s_tuser[3:2];
            item_reg.write_data <= s_tdata;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (exec) begin
            rd_reg  <= result.read_data;
            irq_reg <= result.timer_irq;
        end
    end

    hct_core #(
        .CLOCKS_PER_TICK (CLOCKS_PER_TICK)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .exec     (exec),
        .item     (item_reg),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = rd_reg;
    assign m_tuser[0] = irq_reg;

endmodule

// ===== tb/handheld_console_timer_test.sv =====
// Self-checking testbench for handheld_console_timer: drives bus items, predicts each result.
// Depends on hct_pkg and the handheld_console_timer RTL; reads no files.
`timescale 1ns / 1ps

module handheld_console_timer_test;
    import hct_pkg::*;

    // Command code that the block answers with zeros and otherwise ignores.
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CLOCKS_PER_TICK = 4;
    localparam int TAC_ENABLE = 2;
    // Divider bit watched for each rate code 0..3.
    localparam int RATE_TAP [4] = '{9, 3, 5, 7};
    localparam int IDLE_PCT = 26;

    // Predicts the timer state and keeps the results still to come.
    class timer_scoreboard;
        logic [15:0] div_count;
        logic [7:0]  tima;
        logic [7:0]  tma;
        logic [2:0]  tac;
        bit          prev_edge;
        hct_phase_t  phase;
        hct_result_t awaited [$];
        int          errors;

        function new();
            div_count = DIV_START_RESET;
            tima = 8'h00;
            tma = 8'h00;
            tac = 3'b000;
            prev_edge = 1'b0;
            phase = PH_NONE;
            errors = 0;
        endfunction

        // A divider start write also loads the running divider.
        function void load_divider(logic [15:0] value);
            div_count = value;
        endfunction

        function void bump_counter();
            if (tima == 8'hFF) begin
                tima = 8'h00;
                phase = PH_OVF;
            end else begin
                tima = tima + 8'd1;
            end
        endfunction

        // Works out the one result that an accepted item causes.
        function void note_item(hct_item_t item);
            hct_result_t res;
            bit enabled;
            bit edge_now;
            int tap;
            res = '0;
            case (item.cmd)
                CMD_TICK: begin
                    // Rate and enable are sampled once per machine cycle.
                    enabled = tac[TAC_ENABLE];
                    tap = RATE_TAP[tac[1:0]];
                    if (phase == PH_OVF) begin
                        tima = tma;
                        res.timer_irq = 1'b1;
                        phase = PH_IRQ;
                    end else begin
                        phase = PH_NONE;
                    end
                    for (int i = 0; i < CLOCKS_PER_TICK; i++) begin
                        div_count = div_count + 16'd1;
                        edge_now = enabled && div_count[tap];
                        if (prev_edge && !edge_now)
                            bump_counter();
                        prev_edge = edge_now;
                    end
                end
                CMD_WRITE: begin
                    case (item.reg_sel)
                        SEL_DIV: div_count = 16'h0000;
                        SEL_TIMA: begin
                            // Overflowed: the write wins and cancels the reload.
                            if (phase == PH_OVF) begin
                                tima = item.write_data;
                                phase = PH_NONE;
                            end else if (phase != PH_IRQ) begin
                                tima = item.write_data;
                            end
                        end
                        SEL_TMA: begin
                            tma = item.write_data;
                            if (phase == PH_IRQ)
                                tima = item.write_data;
                        end
                        default: begin
                            tac = item.write_data[2:0];
                            // Disabling while the watched bit is high looks like a falling edge.
                            if (prev_edge && !tac[TAC_ENABLE]) begin
                                bump_counter();
                                prev_edge = 1'b0;
                            end
                        end
                    endcase
                end
                CMD_READ: begin
                    case (item.reg_sel)
                        SEL_DIV:  res.read_data = div_count[15:8];
                        SEL_TIMA: res.read_data = tima;
                        SEL_TMA:  res.read_data = tma;
                        default:  res.read_data = TAC_READ_FILL | {5'b00000, tac};
                    endcase
                end
                default: ;
            endcase
            awaited.push_back(res);
        endfunction

        // Compares a result with the oldest prediction.
        function void check_result(logic [7:0] read_data, logic timer_irq);
            hct_result_t exp_res;
            if (awaited.size() == 0) begin
                $display("%0t: result with none expected, read_data %02h timer_irq %0b",
                         $time, read_data, timer_irq);
                errors++;
                return;
            end
            exp_res = awaited.pop_front();
            if (read_data !== exp_res.read_data) begin
                $display("%0t: read_data expected %02h, got %02h",
                         $time, exp_res.read_data, read_data);
                errors++;
            end
            if (timer_irq !== exp_res.timer_irq) begin
                $display("%0t: timer_irq expected %0b, got %0b",
                         $time, exp_res.timer_irq, timer_irq);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [3:0]  s_tuser = 4'h0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    timer_scoreboard sb = new();
    bit steady = 1'b0;   // no idling on either side while set
    int hold_left = 0;   // receiver hold-off still to run, in cycles
    int sent = 0;

    handheld_console_timer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Offers one item, with random idle cycles first, and waits until it is taken.
    task automatic send_item(input logic [1:0] cmd, input logic [1:0] sel,
                             input logic [7:0] data);
        hct_item_t item;
        item.cmd = cmd;
        item.reg_sel = sel;
        item.write_data = data;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= {sel, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_item(item);
        sent++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Writes the divider start value; only called with the block idle.
    task automatic write_divider_start(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.load_divider(value);
    endtask

    // One unstructured item: mostly ticks, then writes, reads and a few unused commands.
    task automatic send_random();
        int pick;
        logic [1:0] sel;
        logic [7:0] data;
        pick = $urandom_range(0, 99);
        sel = 2'($urandom_range(0, 3));
        data = 8'($urandom_range(0, 255));
        if (pick < 55)
            send_item(CMD_TICK, sel, data);
        else if (pick < 75) begin
            if (sel == SEL_TIMA && $urandom_range(0, 1) == 1)
                data = 8'($urandom_range(8'hF0, 8'hFF));
            if (sel == SEL_TAC && $urandom_range(0, 3) != 0)
                data[TAC_ENABLE] = 1'b1;
            send_item(CMD_WRITE, sel, data);
        end else if (pick < 95)
            send_item(CMD_READ, sel, data);
        else
            send_item(CMD_NONE, sel, data);
    endtask

    // Enables a usually fast rate, sets the counter near overflow and ticks through the reload.
    task automatic overflow_burst();
        logic [7:0] data;
        int ticks;
        data = 8'($urandom_range(0, 255));
        data[TAC_ENABLE] = 1'b1;
        if ($urandom_range(0, 7) != 0)
            data[1:0] = 2'($urandom_range(1, 3));
        send_item(CMD_WRITE, SEL_TAC, data);
        send_item(CMD_WRITE, SEL_TIMA, 8'($urandom_range(8'hF0, 8'hFF)));
        send_item(CMD_WRITE, SEL_TMA, 8'($urandom_range(0, 255)));
        ticks = $urandom_range(6, 14);
        repeat (ticks) begin
            if ($urandom_range(0, 3) == 0)
                send_random();
            else
                send_item(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_run(input int count);
        int stop;
        stop = sent + count;
        while (sent < stop) begin
            if ($urandom_range(0, 99) < 70)
                overflow_burst();
            else
                send_random();
        end
    endtask

    // Walks through the register quirks from the reset state.
    task automatic directed_items();
        send_item(CMD_READ, SEL_DIV, 8'h00);
        send_item(CMD_READ, SEL_TAC, 8'hFF);
        send_item(CMD_WRITE, SEL_TAC, 8'hFD);
        send_item(CMD_WRITE, SEL_TIMA, 8'hFF);
        // The second tick overflows the counter.
        repeat (2) send_item(CMD_TICK, SEL_DIV, 8'h00);
        // Counter write while overflowed cancels the reload.
        send_item(CMD_WRITE, SEL_TIMA, 8'h00);
        send_item(CMD_READ, SEL_TIMA, 8'h00);
        send_item(CMD_WRITE, SEL_TIMA, 8'hFF);
        repeat (4) send_item(CMD_TICK, SEL_TAC, 8'hFF);
        // Reload tick raises the interrupt, then writes land in the reload window.
        send_item(CMD_TICK, SEL_TIMA, 8'h00);
        send_item(CMD_WRITE, SEL_TIMA, 8'h77);
        send_item(CMD_WRITE, SEL_TMA, 8'h3C);
        send_item(CMD_READ, SEL_TIMA, 8'h00);
        send_item(CMD_TICK, SEL_TMA, 8'h00);
        // Divider clear while the watched bit is high gives a falling edge next tick.
        send_item(CMD_WRITE, SEL_DIV, 8'hFF);
        send_item(CMD_TICK, SEL_DIV, 8'h00);
        send_item(CMD_READ, SEL_DIV, 8'h00);
        send_item(CMD_TICK, SEL_DIV, 8'h00);
        // Disabling with the watched bit high gives one extra increment.
        send_item(CMD_WRITE, SEL_TAC, 8'h02);
        send_item(CMD_NONE, SEL_TAC, 8'hFF);
        send_item(CMD_READ, SEL_TMA, 8'h00);
        send_item(CMD_READ, SEL_TAC, 8'h00);
    endtask

    // Result side: checks each accepted result and stalls at random.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Main sequence: reset, directed items, then random phases under several start values.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        random_run(275);

        drain();
        write_divider_start(16'h0000);
        random_run(150);
        // The sender waits here until every result is back.
        drain();
        random_run(150);

        drain();
        write_divider_start(16'hFFFF);
        steady = 1'b1;
        random_run(300);
        steady = 1'b0;

        drain();
        write_divider_start(16'($urandom_range(0, 16'hFFFF)));
        // A long receiver stall while items keep coming fills the block.
        hold_left = 80;
        random_run(300);

        drain();
        write_divider_start(16'h01FE);
        random_run(300);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
